// ===== rtl/core/cumt_pkg.sv =====
package cumt_pkg;

	typedef enum logic [1:0] {
		ACT_GET  = 2'd0,
		ACT_ADD  = 2'd1,
		ACT_DEL  = 2'd2,
		ACT_FIND = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_EXISTS    = 3'd2,
		ST_INVALID   = 3'd3,
		ST_NO_PERM   = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_COPY = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	localparam int CALL_W = 56;
	localparam int UID_W  = 32;

endpackage

// ===== rtl/core/callsign_uid_map_table_top.sv =====
// Callsign to user-id table holding up to TABLE_ENTRIES pairs, newest first, one result word
// per request word. Entries sit in a memory in insertion order behind a fill count, so reset
// needs no clearing pass. A request is taken only while the block is idle. Get, find and add
// scan the table from the newest entry through the single read port of the entry memory, one
// entry per cycle, and stop at the first match. A delete also closes the gap behind the removed
// entry, moving the newer entries down one place per cycle through that same port. Requests
// refused for lack of privilege skip the scan. A finished result waits in an output register
// and the next result is held back until it has been taken.
module callsign_uid_map_table_top #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              action,
	input  logic [55:0]             callsign,
	input  logic [31:0]             user_id,
	input  logic                    privileged,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              status,
	output logic [31:0]             found_uid,
	output logic [55:0]             found_callsign
);
	import cumt_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	state_t               state_q;
	logic [CW-1:0]        cnt_q;
	logic [IW-1:0]        ptr_q;
	logic [CW-1:0]        left_q;

	act_t                 act_q;
	logic [CALL_W-1:0]    call_q;
	logic [UID_W-1:0]     uid_q;

	logic                 iss_s1;
	logic [IW-1:0]        addr_s1;
	logic [UID_W-1:0]     rd_uid_s1;
	logic [CALL_W-1:0]    rd_call_s1;

	status_t              res_st_q;
	logic [UID_W-1:0]     res_uid_q;
	logic [CALL_W-1:0]    res_call_q;

	logic                 out_valid_q;
	status_t              status_q;
	logic [UID_W-1:0]     found_uid_q;
	logic [CALL_W-1:0]    found_call_q;

	logic [UID_W-1:0]     mem_uid [TABLE_ENTRIES];
	logic [CALL_W-1:0]    mem_call [TABLE_ENTRIES];

	logic                 mem_we;
	logic [IW-1:0]        mem_wa;
	logic [UID_W-1:0]     mem_wd_uid;
	logic [CALL_W-1:0]    mem_wd_call;

	logic                 by_call;
	logic [CALL_W-1:0]    cmp_a;
	logic [CALL_W-1:0]    cmp_b;
	logic                 hit;
	logic                 issue;
	logic                 scan_done;
	logic                 copy_done;
	logic                 full;
	logic                 add_ok;

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_uid      = found_uid_q;
	assign found_callsign = found_call_q;

	// The one compare unit: callsign keys for get and delete, uid keys for add and find.
	assign by_call   = (act_q == ACT_GET) || (act_q == ACT_DEL);
	assign cmp_a     = by_call ? rd_call_s1 : CALL_W'(rd_uid_s1);
	assign cmp_b     = by_call ? call_q : CALL_W'(uid_q);
	assign hit       = iss_s1 && (cmp_a == cmp_b);
	assign issue     = (left_q != '0);
	assign scan_done = hit || (!issue && !iss_s1);
	assign copy_done = !issue && !iss_s1;
	assign full      = (cnt_q == CW'(TABLE_ENTRIES));
	assign add_ok    = (state_q == S_SCAN) && scan_done && (act_q == ACT_ADD) && !hit
		&& (uid_q != '0) && !full;

	always_comb begin
		mem_we      = 1'b0;
		mem_wa      = IW'(cnt_q);
		mem_wd_uid  = uid_q;
		mem_wd_call = call_q;
		if (add_ok) begin
			mem_we = 1'b1;
		end else if (state_q == S_COPY && iss_s1) begin
			mem_we      = 1'b1;
			mem_wa      = addr_s1 - IW'(1);
			mem_wd_uid  = rd_uid_s1;
			mem_wd_call = rd_call_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_uid[mem_wa]  <= mem_wd_uid;
			mem_call[mem_wa] <= mem_wd_call;
		end
		rd_uid_s1  <= mem_uid[ptr_q];
		rd_call_s1 <= mem_call[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			left_q      <= '0;
			iss_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			act_q       <= ACT_GET;
			res_st_q    <= ST_OK;
			status_q    <= ST_OK;
		end else begin
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					iss_s1 <= 1'b0;
					if (in_valid) begin
						act_q      <= act_t'(action);
						call_q     <= callsign;
						uid_q      <= user_id;
						ptr_q      <= IW'(cnt_q - CW'(1));
						left_q     <= cnt_q;
						res_uid_q  <= '0;
						res_call_q <= '0;
						if (!privileged && (action == ACT_ADD || action == ACT_DEL)) begin
							res_st_q <= ST_NO_PERM;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// Reads run one entry ahead of the compare, newest entry first.
					addr_s1 <= ptr_q;
					iss_s1  <= issue && !scan_done;
					if (scan_done && hit && act_q == ACT_DEL) begin
						// Newer entries above the hit move down one place.
						state_q <= S_COPY;
						ptr_q   <= addr_s1 + IW'(1);
						left_q  <= cnt_q - CW'(1) - CW'(addr_s1);
					end else begin
						if (issue) begin
							ptr_q  <= ptr_q - IW'(1);
							left_q <= left_q - CW'(1);
						end
						if (scan_done) begin
							state_q <= S_RESP;
						end
					end
					if (scan_done) begin
						case (act_q)
							ACT_GET: begin
								res_st_q  <= hit ? ST_OK : ST_NOT_FOUND;
								res_uid_q <= hit ? rd_uid_s1 : '0;
							end
							ACT_FIND: begin
								res_st_q   <= hit ? ST_OK : ST_NOT_FOUND;
								res_uid_q  <= hit ? rd_uid_s1 : '0;
								res_call_q <= hit ? rd_call_s1 : '0;
							end
							ACT_ADD: begin
								if (hit) begin
									res_st_q <= ST_EXISTS;
								end else if (uid_q == '0) begin
									res_st_q <= ST_INVALID;
								end else if (full) begin
									res_st_q <= ST_FULL;
								end else begin
									res_st_q <= ST_OK;
									cnt_q    <= cnt_q + CW'(1);
								end
							end
							default: begin
								res_st_q <= hit ? ST_OK : ST_NOT_FOUND;
							end
						endcase
					end
				end
				S_COPY: begin
					if (issue) begin
						ptr_q  <= ptr_q + IW'(1);
						left_q <= left_q - CW'(1);
					end
					addr_s1 <= ptr_q;
					iss_s1  <= issue;
					if (copy_done) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						status_q     <= res_st_q;
						found_uid_q  <= res_uid_q;
						found_call_q <= res_call_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_ENTRIES))
		else $error("fill count beyond table size");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> (cnt_q == $past(cnt_q) + CW'(1))
			|| (cnt_q == $past(cnt_q) - CW'(1)))
		else $error("fill count moved by more than one");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && iss_s1) |-> (CW'(addr_s1) < cnt_q))
		else $error("scan read outside the filled part of the table");

	a_copy_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) |-> (cnt_q != '0))
		else $error("compaction on an empty table");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && out_valid_q && !out_ready) |=> (state_q == S_RESP))
		else $error("result dropped while the previous one waits");

endmodule

// ===== dv/tb_callsign_uid_map_table_top.sv =====
module tb_callsign_uid_map_table_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cumt_pkg::*;

	localparam int MAP_DEPTH = 16;
	localparam int RANDOM_REQS = 1200;

	typedef struct {
		act_t              act;
		logic [CALL_W-1:0] call;
		logic [UID_W-1:0]  uid;
		logic              priv;
	} map_req_t;

	typedef struct {
		status_t           status;
		logic [UID_W-1:0]  uid;
		logic [CALL_W-1:0] call;
	} map_resp_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        action = ACT_GET;
	logic [CALL_W-1:0] callsign = '0;
	logic [UID_W-1:0]  user_id = '0;
	logic              privileged = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        status;
	logic [UID_W-1:0]  found_uid;
	logic [CALL_W-1:0] found_callsign;

	// Predicted table contents, newest pair at index 0.
	logic              map_used[MAP_DEPTH];
	logic [UID_W-1:0]  map_uid[MAP_DEPTH];
	logic [CALL_W-1:0] map_call[MAP_DEPTH];

	map_req_t  pending_reqs[$];
	map_resp_t expected_resps[$];

	int reqs_total;
	int reqs_sent = 0;
	int reqs_taken = 0;
	int resps_seen = 0;
	int resps_acked = 0;
	int send_gap = 0;
	int send_burst = 0;
	int recv_gap = 0;
	int recv_burst = 0;
	int err_cnt = 0;

	logic [CALL_W-1:0] call_pool[20];
	logic [UID_W-1:0]  uid_pool[40];

	callsign_uid_map_table_top #(
		.TABLE_ENTRIES(MAP_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.callsign      (callsign),
		.user_id       (user_id),
		.privileged    (privileged),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.found_uid     (found_uid),
		.found_callsign(found_callsign)
	);

	always #5 clk = ~clk;

	function automatic logic [CALL_W-1:0] rand_call();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[CALL_W-1:0];
	endfunction

	// Mostly a random gap before each word, with occasional runs of back-to-back words.
	function automatic int draw_wait(ref int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	function automatic void queue_req(act_t a, logic [CALL_W-1:0] c, logic [UID_W-1:0] u,
			logic p);
		map_req_t r;
		r.act = a;
		r.call = c;
		r.uid = u;
		r.priv = p;
		pending_reqs.push_back(r);
	endfunction

	function automatic int newest_call(logic [CALL_W-1:0] c);
		for (int i = 0; i < MAP_DEPTH; i++)
			if (map_used[i] && map_call[i] == c)
				return i;
		return -1;
	endfunction

	function automatic int newest_uid(logic [UID_W-1:0] u);
		for (int i = 0; i < MAP_DEPTH; i++)
			if (map_used[i] && map_uid[i] == u)
				return i;
		return -1;
	endfunction

	// Applies one accepted request to the predicted table and queues its result word.
	function automatic void model_request(act_t a, logic [CALL_W-1:0] c, logic [UID_W-1:0] u,
			logic p);
		map_resp_t r;
		int k;
		r.status = ST_OK;
		r.uid = '0;
		r.call = '0;
		case (a)
			ACT_GET: begin
				k = newest_call(c);
				if (k < 0)
					r.status = ST_NOT_FOUND;
				else
					r.uid = map_uid[k];
			end
			ACT_ADD: begin
				if (!p)
					r.status = ST_NO_PERM;
				else if (newest_uid(u) >= 0)
					r.status = ST_EXISTS;
				else if (u == '0)
					r.status = ST_INVALID;
				else if (map_used[MAP_DEPTH-1])
					r.status = ST_FULL;
				else begin
					for (int i = MAP_DEPTH - 1; i > 0; i--) begin
						map_used[i] = map_used[i-1];
						map_uid[i] = map_uid[i-1];
						map_call[i] = map_call[i-1];
					end
					map_used[0] = 1'b1;
					map_uid[0] = u;
					map_call[0] = c;
				end
			end
			ACT_DEL: begin
				k = newest_call(c);
				if (!p)
					r.status = ST_NO_PERM;
				else if (k < 0)
					r.status = ST_NOT_FOUND;
				else begin
					for (int i = k; i < MAP_DEPTH - 1; i++) begin
						map_used[i] = map_used[i+1];
						map_uid[i] = map_uid[i+1];
						map_call[i] = map_call[i+1];
					end
					map_used[MAP_DEPTH-1] = 1'b0;
				end
			end
			default: begin
				k = newest_uid(u);
				if (k < 0)
					r.status = ST_NOT_FOUND;
				else begin
					r.uid = map_uid[k];
					r.call = map_call[k];
				end
			end
		endcase
		expected_resps.push_back(r);
	endfunction

	// Request side: a word stays on the port until the monitor has seen it taken.
	always @(negedge clk) begin
		logic vld;
		map_req_t nxt;
		if (arst_n) begin
			vld = in_valid;
			if (vld && reqs_taken == reqs_sent) begin
				vld = 1'b0;
				send_gap = draw_wait(send_burst);
			end
			if (!vld && pending_reqs.size() > 0) begin
				if (send_gap == 0) begin
					nxt = pending_reqs.pop_front();
					action <= nxt.act;
					callsign <= nxt.call;
					user_id <= nxt.uid;
					privileged <= nxt.priv;
					reqs_sent++;
					vld = 1'b1;
				end else
					send_gap--;
			end
			in_valid <= vld;
		end
	end

	// Result side: after each word taken, hold ready low for a random number of cycles.
	always @(negedge clk) begin
		if (arst_n) begin
			if (resps_seen != resps_acked) begin
				resps_acked = resps_seen;
				recv_gap = draw_wait(recv_burst);
			end
			if (recv_gap == 0)
				out_ready <= 1'b1;
			else begin
				out_ready <= 1'b0;
				recv_gap--;
			end
		end
	end

	always @(posedge clk) begin
		map_resp_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				resps_seen++;
				if (expected_resps.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: result word with none expected:", $realtime,
							" status %0d uid %h call %h",
							status, found_uid, found_callsign);
				end else begin
					exp_r = expected_resps.pop_front();
					if (status !== exp_r.status || found_uid !== exp_r.uid ||
							found_callsign !== exp_r.call) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$display("%0t: mismatch: expected status %0d uid %h call %h",
								$realtime, exp_r.status, exp_r.uid, exp_r.call);
							$display("%0t:           got status %0d uid %h call %h",
								$realtime, status, found_uid, found_callsign);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				reqs_taken++;
				model_request(act_t'(action), callsign, user_id, privileged);
			end
		end
	end

	initial begin
		int add_pct;
		int del_pct;
		int pick;
		act_t a;
		logic [CALL_W-1:0] c;
		logic [UID_W-1:0] u;
		logic p;

		for (int i = 0; i < MAP_DEPTH; i++)
			map_used[i] = 1'b0;

		// Empty table, a privilege refusal and an invalid uid.
		queue_req(ACT_GET, '0, '0, 1'b0);
		queue_req(ACT_FIND, '1, '0, 1'b0);
		queue_req(ACT_DEL, '1, '1, 1'b1);
		queue_req(ACT_ADD, '1, '1, 1'b0);
		queue_req(ACT_ADD, 56'h5, '0, 1'b1);
		// Extreme values, an existing uid, and a duplicate callsign shadowing an older one.
		queue_req(ACT_ADD, '1, '1, 1'b1);
		queue_req(ACT_ADD, '0, 32'h1, 1'b1);
		queue_req(ACT_ADD, 56'h3, '1, 1'b1);
		queue_req(ACT_ADD, '0, 32'h2, 1'b1);
		queue_req(ACT_GET, '0, '0, 1'b0);
		queue_req(ACT_FIND, '0, '1, 1'b0);
		queue_req(ACT_DEL, '0, '0, 1'b0);
		queue_req(ACT_DEL, '0, '0, 1'b1);
		queue_req(ACT_GET, '0, '1, 1'b1);
		// Fill the table, then hit it with a fresh uid and with an existing one.
		for (int i = 0; i < MAP_DEPTH - 2; i++)
			queue_req(ACT_ADD, rand_call(), 32'h100 + i, 1'b1);
		queue_req(ACT_ADD, rand_call(), 32'h200, 1'b1);
		queue_req(ACT_ADD, rand_call(), 32'h1, 1'b1);

		// Small pools keep hits and duplicate callsigns frequent.
		call_pool[0] = '0;
		call_pool[1] = '1;
		for (int i = 2; i < 20; i++)
			call_pool[i] = rand_call();
		uid_pool[0] = '0;
		uid_pool[1] = '1;
		for (int i = 2; i < 40; i++)
			uid_pool[i] = $urandom();

		add_pct = 50;
		del_pct = 20;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			// Each phase shifts the add/delete balance so the table fills and drains.
			if (n % 60 == 0) begin
				add_pct = $urandom_range(10, 70);
				del_pct = $urandom_range(5, 35);
				for (int j = 0; j < 4; j++) begin
					call_pool[$urandom_range(2, 19)] = rand_call();
					uid_pool[$urandom_range(2, 39)] = $urandom();
				end
			end
			pick = $urandom_range(0, 99);
			if (pick < add_pct)
				a = ACT_ADD;
			else if (pick < add_pct + del_pct)
				a = ACT_DEL;
			else if ($urandom_range(0, 1) == 0)
				a = ACT_GET;
			else
				a = ACT_FIND;
			p = ($urandom_range(0, 9) != 0);
			if ($urandom_range(0, 99) < 8) begin
				c = rand_call();
				u = $urandom();
				a = act_t'($urandom_range(0, 3));
				p = 1'($urandom_range(0, 1));
			end else begin
				c = call_pool[$urandom_range(0, 19)];
				u = uid_pool[$urandom_range(0, 39)];
			end
			queue_req(a, c, u, p);
		end
		reqs_total = pending_reqs.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (reqs_taken != reqs_total)
			@(posedge clk);
		while (expected_resps.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (err_cnt == 0 && expected_resps.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
